// File: rtl/core/fba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame bitmap allocator package
// Transaction types and operation codes shared by the allocator core and its testbench.
// ----------------------------------------------------------------------------
package fba_pkg;

    typedef enum logic [1:0] {
        KIND_ALLOC_ONE = 2'd0,
        KIND_ALLOC_RUN = 2'd1,
        KIND_RELEASE   = 2'd2,
        KIND_RESERVE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] first_frame;
        logic [16:0] frame_count;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] frame_id;
        logic [16:0] free_count;
    } rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/fba_word_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame bitmap allocator word unit
// Processes one bitmap word at a time, combinationally: range masking, a prefix-based run scan
// and first-free search within the word, and the population change of the word.
// ----------------------------------------------------------------------------
module fba_word_unit #(
    parameter int WB = 64,
    parameter int FW = 17
) (
    input  wire logic [WB-1:0] word,
    input  wire logic [WB-1:0] range_mask,
    input  wire logic          set_free,
    input  wire logic          find_one,
    input  wire logic [FW-1:0] run_in,
    input  wire logic [FW-1:0] run_start_in,
    input  wire logic [FW-1:0] word_base,
    input  wire logic [FW-1:0] run_goal,
    output logic      [WB-1:0] word_out,
    output logic      [FW-1:0] delta,
    output logic               delta_up,
    output logic               one_hit,
    output logic      [FW-1:0] one_pos,
    output logic               run_hit,
    output logic      [FW-1:0] run_start_out,
    output logic      [FW-1:0] run_end_out,
    output logic      [FW-1:0] run_out
);

    localparam int BW = $clog2(WB);

    logic [WB-1:0] flips;
    logic [WB-1:0] cand;
    logic [BW:0]   zmark [WB];
    logic [FW-1:0] len   [WB];

    always_comb
    begin
        cand = word & range_mask;
        if (set_free)
        begin
            flips    = range_mask & ~word;
            word_out = word | range_mask;
        end
        else
        begin
            flips    = cand;
            word_out = word & ~range_mask;
        end
        delta    = FW'($countones(flips));
        delta_up = set_free;
    end

    always_comb
    begin
        one_hit = 1'b0;
        one_pos = '0;
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (find_one && cand[i])
            begin
                one_hit = 1'b1;
                one_pos = word_base + FW'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < WB; i++)
        begin
            zmark[i] = word[i] ? (BW+1)'(0) : (BW+1)'(i + 1);
        end
        for (int d = 1; d < WB; d = d * 2)
        begin
            for (int i = WB - 1; i >= d; i--)
            begin
                if (zmark[i - d] > zmark[i])
                begin
                    zmark[i] = zmark[i - d];
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < WB; i++)
        begin
            if (zmark[i] == '0)
            begin
                len[i] = run_in + FW'(i + 1);
            end
            else
            begin
                len[i] = FW'(i + 1) - FW'(zmark[i]);
            end
        end
    end

    always_comb
    begin
        run_hit       = 1'b0;
        run_start_out = (zmark[WB-1] == '0 && run_in != '0) ? run_start_in
                                                            : word_base + FW'(zmark[WB-1]);
        run_end_out   = '0;
        run_out       = len[WB-1];
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (len[i] == run_goal)
            begin
                run_hit       = 1'b1;
                run_start_out = (zmark[i] == '0 && run_in != '0) ? run_start_in
                                                                 : word_base + FW'(zmark[i]);
                run_end_out   = word_base + FW'(i);
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/frame_bitmap_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame bitmap allocator core
// Each request transaction allocates one frame (next fit), allocates a run of
// frames (first fit), releases a range or reserves a range. Exactly one
// response transaction follows every request. The bitmap sits in a word-wide
// memory, and one shared word unit visits one word at a time: each word is
// read and then evaluated, and a word that is changed is written back.
// A single allocation reads up to NUM_FRAMES/MAP_WORD_BITS + 1 words, a run
// allocation scans up to all words and then reads and writes back each word
// of the run, and a range operation reads, evaluates and writes each word
// that holds the range. The worst case is a run that spans the whole map.
// A zero-length run, a run longer than the map or an empty range answers in
// the cycle after it is taken. req_stall is high while a request is at work
// or its response waits.
// At reset the whole bitmap is cleared by a pass over every word, during
// which no request is taken; the free count and hint are zero.
// The response is held in a register while rsp_stall is high; a new request
// is taken once that response has gone.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core #(
    parameter int NUM_FRAMES    = 65536,
    parameter int MAP_WORD_BITS = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire fba_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output fba_pkg::rsp_t      rsp
);

    localparam int WB    = MAP_WORD_BITS;
    localparam int WORDS = (NUM_FRAMES + WB - 1) / WB;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(WB);
    localparam int FW    = $clog2(NUM_FRAMES + 1) + 1;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b00000001,
        ST_IDLE  = 8'b00000010,
        ST_READ  = 8'b00000100,
        ST_EXEC  = 8'b00001000,
        ST_WRITE = 8'b00010000,
        ST_RUNWR = 8'b00100000,
        ST_RUNRD = 8'b01000000,
        ST_RESP  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [WB-1:0] mem [WORDS];
    logic [WB-1:0] rdata_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [WB-1:0] wdata;
    logic [AW-1:0] raddr;

    logic [1:0]    kind_reg;
    logic [FW-1:0] lo_reg, lo_next;
    logic [FW-1:0] hi_reg, hi_next;
    logic [FW-1:0] goal_reg;
    logic [15:0]   echo_reg;
    logic [AW:0]   addr_reg, addr_next;
    logic [AW:0]   steps_reg, steps_next;
    logic          wrap_reg, wrap_next;
    logic [FW-1:0] run_reg, run_next;
    logic [FW-1:0] rstart_reg, rstart_next;
    logic [FW-1:0] free_reg, free_next;
    logic [FW-1:0] hint_reg, hint_next;
    logic          ok_reg, ok_next;
    logic [15:0]   idx_reg, idx_next;
    logic [WB-1:0] wword_reg, wword_next;
    logic          rsp_valid_reg;

    logic [FW-1:0] base;
    logic [WB-1:0] mask;
    logic          is_free_op;
    logic [WB-1:0] u_word;
    logic [FW-1:0] u_delta;
    logic          u_up;
    logic          u_one_hit;
    logic [FW-1:0] u_one_pos;
    logic          u_run_hit;
    logic [FW-1:0] u_rs;
    logic [FW-1:0] u_re;
    logic [FW-1:0] u_run;

    logic [FW-1:0] hcl;
    logic [FW:0]   req_end;
    logic [FW-1:0] req_hi;

    assign base = FW'(addr_reg[AW-1:0]) << BW;

    always_comb
    begin
        for (int i = 0; i < WB; i++)
        begin
            mask[i] = ((base + FW'(i)) >= lo_reg) && ((base + FW'(i)) < hi_reg)
                      && ((base + FW'(i)) < FW'(NUM_FRAMES));
        end
    end

    assign is_free_op = (kind_reg == fba_pkg::KIND_RELEASE);

    fba_word_unit #(.WB(WB), .FW(FW)) u_unit (
        .word          (rdata_reg),
        .range_mask    (mask),
        .set_free      (is_free_op),
        .find_one      (kind_reg == fba_pkg::KIND_ALLOC_ONE),
        .run_in        (run_reg),
        .run_start_in  (rstart_reg),
        .word_base     (base),
        .run_goal      (goal_reg),
        .word_out      (u_word),
        .delta         (u_delta),
        .delta_up      (u_up),
        .one_hit       (u_one_hit),
        .one_pos       (u_one_pos),
        .run_hit       (u_run_hit),
        .run_start_out (u_rs),
        .run_end_out   (u_re),
        .run_out       (u_run)
    );

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        hcl     = (hint_reg >= FW'(NUM_FRAMES)) ? '0 : hint_reg;
        req_end = (FW+1)'(req.first_frame) + (FW+1)'(req.frame_count);
        req_hi  = (req_end > (FW+1)'(NUM_FRAMES)) ? FW'(NUM_FRAMES) : FW'(req_end);
    end

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        addr_next   = addr_reg;
        steps_next  = steps_reg;
        wrap_next   = wrap_reg;
        run_next    = run_reg;
        rstart_next = rstart_reg;
        free_next   = free_reg;
        hint_next   = hint_reg;
        ok_next     = ok_reg;
        idx_next    = idx_reg;
        wword_next  = wword_reg;
        we          = 1'b0;
        waddr       = addr_reg[AW-1:0];
        wdata       = wword_reg;
        raddr       = addr_reg[AW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                wdata = '0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == (AW+1)'(WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ok_next     = 1'b1;
                    idx_next    = req.first_frame;
                    run_next    = '0;
                    rstart_next = '0;
                    wrap_next   = 1'b0;
                    steps_next  = '0;
                    case (req.kind)
                        fba_pkg::KIND_ALLOC_ONE:
                        begin
                            lo_next    = hcl;
                            hi_next    = FW'(NUM_FRAMES);
                            addr_next  = (AW+1)'(hcl >> BW);
                            state_next = ST_READ;
                        end
                        fba_pkg::KIND_ALLOC_RUN:
                        begin
                            lo_next   = '0;
                            hi_next   = FW'(NUM_FRAMES);
                            addr_next = '0;
                            if (req.frame_count == '0
                                || FW'(req.frame_count) > FW'(NUM_FRAMES))
                            begin
                                ok_next    = 1'b0;
                                idx_next   = '0;
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            lo_next   = FW'(req.first_frame);
                            hi_next   = req_hi;
                            addr_next = (AW+1)'(req.first_frame >> BW);
                            if (FW'(req.first_frame) >= req_hi)
                            begin
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                case (kind_reg)
                    fba_pkg::KIND_ALLOC_ONE:
                    begin
                        if (u_one_hit)
                        begin
                            wword_next = rdata_reg & ~(WB'(1) << u_one_pos[BW-1:0]);
                            free_next  = free_reg - 1'b1;
                            hint_next  = u_one_pos + 1'b1;
                            idx_next   = u_one_pos[15:0];
                            state_next = ST_WRITE;
                        end
                        else if (steps_reg == (AW+1)'(WORDS))
                        begin
                            ok_next    = 1'b0;
                            idx_next   = '0;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            steps_next = steps_reg + 1'b1;
                            if (addr_reg == (AW+1)'(WORDS - 1) || wrap_reg)
                            begin
                                if (!wrap_reg)
                                begin
                                    wrap_next = 1'b1;
                                    lo_next   = '0;
                                    hi_next   = hcl;
                                    addr_next = '0;
                                end
                                else
                                begin
                                    addr_next = addr_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                addr_next = addr_reg + 1'b1;
                            end
                            if (wrap_reg && (base + FW'(WB)) >= hi_reg)
                            begin
                                ok_next    = 1'b0;
                                idx_next   = '0;
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                    end
                    fba_pkg::KIND_ALLOC_RUN:
                    begin
                        run_next    = u_run;
                        rstart_next = u_rs;
                        if (u_run_hit)
                        begin
                            lo_next    = u_rs;
                            hi_next    = u_re + 1'b1;
                            idx_next   = u_rs[15:0];
                            addr_next  = (AW+1)'(u_rs >> BW);
                            state_next = ST_RUNRD;
                        end
                        else if (addr_reg == (AW+1)'(WORDS - 1))
                        begin
                            ok_next    = 1'b0;
                            idx_next   = '0;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            addr_next  = addr_reg + 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    default:
                    begin
                        wword_next = u_word;
                        free_next  = u_up ? free_reg + u_delta : free_reg - u_delta;
                        state_next = ST_RUNWR;
                    end
                endcase
            end
            ST_WRITE:
            begin
                we         = 1'b1;
                state_next = ST_RESP;
            end
            ST_RUNRD:
            begin
                state_next = ST_RUNWR;
                wword_next = rdata_reg;
            end
            ST_RUNWR:
            begin
                we    = 1'b1;
                wdata = (kind_reg == fba_pkg::KIND_ALLOC_RUN) ? u_word : wword_reg;
                if (kind_reg == fba_pkg::KIND_ALLOC_RUN)
                begin
                    free_next = free_reg - u_delta;
                end
                if ((base + FW'(WB)) >= hi_reg)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = (kind_reg == fba_pkg::KIND_ALLOC_RUN) ? ST_RUNRD : ST_READ;
                end
            end
            ST_RESP:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            free_reg      <= '0;
            hint_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            free_reg      <= free_next;
            hint_reg      <= hint_next;
            rsp_valid_reg <= (state_next == ST_RESP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_valid)
        begin
            kind_reg <= req.kind;
            goal_reg <= FW'(req.frame_count);
            echo_reg <= req.first_frame;
        end
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        steps_reg  <= steps_next;
        wrap_reg   <= wrap_next;
        run_reg    <= run_next;
        rstart_reg <= rstart_next;
        ok_reg     <= ok_next;
        idx_reg    <= idx_next;
        wword_reg  <= wword_next;
    end

    assign req_stall           = (state_reg != ST_IDLE);
    assign rsp_valid           = rsp_valid_reg && (state_reg == ST_RESP);
    assign rsp.ok              = ok_reg;
    assign rsp.frame_id        = (kind_reg[1]) ? echo_reg : idx_reg;
    assign rsp.free_count      = free_reg[16:0];

endmodule
`default_nettype wire

// File: tb/sv/frame_bitmap_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator core testbench
// Sends allocation, run, release and reserve transactions with random gaps and
// response stalls, predicts every response from a bit-level copy of the frame
// map, and compares each response field by field in order of arrival.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core_tb;

    localparam int FRAMES     = 65536;
    localparam int IDLE_LIMIT = 40000;
    localparam int DRAIN_WAIT = 3500;
    localparam int LONG_HOLD  = 400;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    fba_pkg::req_t  req = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b1;
    fba_pkg::rsp_t  rsp;

    bit             frame_free [FRAMES];
    int             model_free_cnt;
    int             next_hint;
    fba_pkg::rsp_t  pending_rsp [$];
    int             errors = 0;
    bit             quiet_mode = 1'b0;
    bit             long_hold = 1'b0;
    event           long_hold_go;
    int             hold_cnt = 0;
    int             idle_cycles = 0;

    frame_bitmap_allocator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    function automatic fba_pkg::rsp_t apply_request(fba_pkg::req_t r);
        fba_pkg::rsp_t o;
        int            f;
        int            run_len;
        int            start;
        int            last;
        o.ok = 1'b1;
        o.frame_id = r.first_frame;
        case (fba_pkg::kind_t'(r.kind))
            fba_pkg::KIND_ALLOC_ONE:
            begin
                o.ok = 1'b0;
                o.frame_id = '0;
                for (int i = 0; i < FRAMES; i++)
                begin
                    f = (next_hint + i) % FRAMES;
                    if (frame_free[f])
                    begin
                        frame_free[f] = 1'b0;
                        model_free_cnt--;
                        next_hint = f + 1;
                        o.ok = 1'b1;
                        o.frame_id = f[15:0];
                        break;
                    end
                end
            end
            fba_pkg::KIND_ALLOC_RUN:
            begin
                o.ok = 1'b0;
                o.frame_id = '0;
                run_len = 0;
                start = 0;
                if (r.frame_count != 0)
                begin
                    for (f = 0; f < FRAMES; f++)
                    begin
                        if (frame_free[f])
                        begin
                            if (run_len == 0)
                                start = f;
                            run_len++;
                            if (run_len == r.frame_count)
                            begin
                                for (int i = start; i <= f; i++)
                                    frame_free[i] = 1'b0;
                                model_free_cnt -= run_len;
                                o.ok = 1'b1;
                                o.frame_id = start[15:0];
                                break;
                            end
                        end
                        else
                            run_len = 0;
                    end
                end
            end
            default:
            begin
                last = r.first_frame + r.frame_count;
                if (last > FRAMES)
                    last = FRAMES;
                for (f = r.first_frame; f < last; f++)
                begin
                    if (fba_pkg::kind_t'(r.kind) == fba_pkg::KIND_RELEASE && !frame_free[f])
                    begin
                        frame_free[f] = 1'b1;
                        model_free_cnt++;
                    end
                    else if (fba_pkg::kind_t'(r.kind) == fba_pkg::KIND_RESERVE
                             && frame_free[f])
                    begin
                        frame_free[f] = 1'b0;
                        model_free_cnt--;
                    end
                end
            end
        endcase
        o.free_count = model_free_cnt[16:0];
        return o;
    endfunction

    task automatic send_request(fba_pkg::kind_t k, int first, int count);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= '{kind: k, first_frame: first[15:0], frame_count: count[16:0]};
        forever
        begin
            @(negedge clk);
            if (!req_stall)
                break;
        end
        @(posedge clk);
        pending_rsp.push_back(apply_request(req));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random();
        int r;
        int k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 3);
        if (r < 8)
            send_request(fba_pkg::kind_t'(k), $urandom_range(0, 65535),
                         $urandom_range(0, 131071));
        else if (k == fba_pkg::KIND_ALLOC_RUN)
            send_request(fba_pkg::KIND_ALLOC_RUN, $urandom_range(0, 65535),
                         (r < 15) ? $urandom_range(0, 4096) : $urandom_range(1, 40));
        else if (k == fba_pkg::KIND_ALLOC_ONE)
            send_request(fba_pkg::KIND_ALLOC_ONE, $urandom_range(0, 65535),
                         $urandom_range(0, 131071));
        else
            send_request(fba_pkg::kind_t'(k), $urandom_range(0, 65535),
                         (r < 20) ? $urandom_range(0, 65536) : $urandom_range(0, 300));
    endtask

    task automatic test_directed_cases();
        send_request(fba_pkg::KIND_ALLOC_ONE, 16'hFFFF, 17'h1FFFF);
        send_request(fba_pkg::KIND_ALLOC_RUN, 0, 0);
        send_request(fba_pkg::KIND_ALLOC_RUN, 0, 1);
        send_request(fba_pkg::KIND_RELEASE, 0, 64);
        send_request(fba_pkg::KIND_ALLOC_ONE, 0, 0);
        send_request(fba_pkg::KIND_ALLOC_RUN, 0, 3);
        send_request(fba_pkg::KIND_ALLOC_RUN, 0, 65536);
        send_request(fba_pkg::KIND_RELEASE, 5, 0);
        send_request(fba_pkg::KIND_RELEASE, 10, 20);
        send_request(fba_pkg::KIND_RELEASE, 65530, 100);
        send_request(fba_pkg::KIND_ALLOC_ONE, 0, 0);
        send_request(fba_pkg::KIND_RELEASE, 0, 65536);
        send_request(fba_pkg::KIND_ALLOC_RUN, 0, 65536);
        send_request(fba_pkg::KIND_RELEASE, 65535, 1);
        send_request(fba_pkg::KIND_ALLOC_ONE, 0, 0);
        send_request(fba_pkg::KIND_RELEASE, 0, 2);
        send_request(fba_pkg::KIND_ALLOC_ONE, 0, 0);
        send_request(fba_pkg::KIND_RESERVE, 0, 0);
        send_request(fba_pkg::KIND_RESERVE, 40000, 131071);
        send_request(fba_pkg::KIND_RELEASE, 65535, 131071);
        send_request(fba_pkg::KIND_RESERVE, 65535, 5);
        send_request(fba_pkg::KIND_RESERVE, 100, 50);
        send_request(fba_pkg::KIND_RELEASE, 32768, 1000);
        send_request(fba_pkg::KIND_ALLOC_RUN, 21845, 65536);
        send_request(fba_pkg::KIND_ALLOC_RUN, 43690, 1000);
    endtask

    task automatic test_random_traffic(int n);
        for (int i = 0; i < n; i++)
            send_random();
    endtask

    task automatic test_no_idle_stretch(int n);
        quiet_mode = 1'b1;
        test_random_traffic(n);
        quiet_mode = 1'b0;
    endtask

    task automatic test_backpressure();
        -> long_hold_go;
        for (int i = 0; i < 8; i++)
            send_random();
    endtask

    task automatic test_drain_pause();
        wait_drained();
        test_random_traffic(20);
    endtask

    always
    begin
        @(long_hold_go);
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        int wait_n;
        if (long_hold)
            rsp_stall <= 1'b1;
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            rsp_stall <= 1'b1;
        end
        else if (rsp_valid && !rsp_stall && !quiet_mode)
        begin
            wait_n = $urandom_range(0, 10);
            hold_cnt <= (wait_n > 0) ? wait_n - 1 : 0;
            rsp_stall <= (wait_n > 0);
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(negedge clk)
    begin
        fba_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected response %p", $time, rsp);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.ok !== want.ok)
                begin
                    $display("%0t: ok expected %0d actual %0d", $time, want.ok, rsp.ok);
                    errors++;
                end
                if (rsp.frame_id !== want.frame_id)
                begin
                    $display("%0t: frame_id expected %0d actual %0d", $time,
                             want.frame_id, rsp.frame_id);
                    errors++;
                end
                if (rsp.free_count !== want.free_count)
                begin
                    $display("%0t: free_count expected %0d actual %0d", $time,
                             want.free_count, rsp.free_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        model_free_cnt = 0;
        next_hint = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic(250);
        test_no_idle_stretch(60);
        test_backpressure();
        test_drain_pause();
        test_random_traffic(220);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
